// ===== rtl/chkv_pkg.sv =====
// chkv_pkg: shared constants, types and codes for the chained hash key-value table
// no dependencies
package chkv_pkg;
  localparam int unsigned BUCKETS = 4096;
  localparam int unsigned ENTRIES = 1024;
  localparam int unsigned BKT_W = $clog2(BUCKETS);
  localparam int unsigned ENT_W = $clog2(ENTRIES);
  localparam int unsigned LNK_W = ENT_W + 1;
  localparam logic [LNK_W-1:0] NO_ENTRY = LNK_W'(ENTRIES);
  localparam logic [LNK_W-1:0] FULL_CNT = LNK_W'(ENTRIES);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_GET = 2'd1;
  localparam logic [1:0] OP_REM = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic        load;      // capture input beat
    logic        clr_step;  // clearing pass write of one bucket head
    logic        advance;   // prev <= cur, cur <= link
    logic        take_head; // cur <= head read data
    logic        do_add;    // write new entry and link it at the head
    logic        do_rem;    // unlink cur and free it
    logic        set_res;   // register result
    logic [1:0]  res_status;
    logic        res_val;   // result carries the found value
  } chkv_cmd_t;

  typedef struct packed {
    logic        clr_last;
    logic [1:0]  op;
    logic        cur_null;
    logic        match;
    logic        steps_out;
    logic        pool_empty;
  } chkv_sts_t;
endpackage

// ===== rtl/chained_hash_key_value_table.sv =====
// chained_hash_key_value_table: top level of the chained hash key-value table
// depends on chkv_pkg, chkv_ctrl, chkv_datapath, chkv_ram
//
// one command beat in, one result beat out. after reset a clearing pass
// empties the bucket head memory, one bucket a cycle, before the first beat
// is taken. the chain walk is paced by the registered read of the key
// memory. opcode 3 answers done. the next command beat is taken the cycle
// after the result beat leaves.
module chained_hash_key_value_table (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode[1:0], key_w0..key_w3, val_in_w0..val_in_w3, zero pad
  input  logic [519:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[1:0], val_out_w0..val_out_w3, zero pad
  output logic [263:0] m_tdata
);
  chkv_pkg::chkv_cmd_t cmd;
  chkv_pkg::chkv_sts_t sts;
  logic [1:0]   res_status;
  logic [255:0] res_val;

  chkv_ctrl u_ctrl (
    .clk, .rst, .in_fire(s_tvalid && s_tready), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready), .sts, .cmd);

  chkv_datapath u_dp (
    .clk, .rst, .cmd, .sts,
    .in_op(s_tdata[1:0]), .in_key(s_tdata[257:2]), .in_val(s_tdata[513:258]),
    .res_status, .res_val);

  assign m_tdata = {6'd0, res_val, res_status};
endmodule

// ===== rtl/chkv_ram.sv =====
// chkv_ram: generic single-port-write, single-read RAM with registered read
// no dependencies
module chkv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/chkv_datapath.sv =====
// chkv_datapath: key capture, chain pointers, memories and result register
// depends on chkv_pkg and chkv_ram
module chkv_datapath (
  input  logic                clk,
  input  logic                rst,
  input  chkv_pkg::chkv_cmd_t cmd,
  output chkv_pkg::chkv_sts_t sts,
  input  logic [1:0]          in_op,
  input  logic [255:0]        in_key,
  input  logic [255:0]        in_val,
  output logic [1:0]          res_status,
  output logic [255:0]        res_val
);
  localparam int unsigned BW = chkv_pkg::BKT_W;
  localparam int unsigned EW = chkv_pkg::ENT_W;
  localparam int unsigned LW = chkv_pkg::LNK_W;

  logic [1:0]   op;
  logic [255:0] key;
  logic [255:0] val;
  logic [BW-1:0] clr_idx;
  logic [LW-1:0] cur, prev, free_cnt, steps;
  logic [BW-1:0] bucket;

  logic [LW-1:0]  head_rd, link_rd;
  logic [255:0]   key_rd, val_rd;
  logic [EW-1:0]  pool_rd;
  logic [EW-1:0]  pop_slot;

  logic           head_we;
  logic [BW-1:0]  head_wa;
  logic [LW-1:0]  head_wd;
  logic           link_we;
  logic [EW-1:0]  link_wa;
  logic [LW-1:0]  link_wd;
  logic           pool_we;
  logic [EW-1:0]  pool_wa, pool_ra;
  logic [EW-1:0]  link_ra;
  logic           rem_head;

  // free pool holds its reset image implicitly: every slot at or above the
  // lowest count ever reached was rewritten since, slot i below it reads i
  logic          pool_written;
  logic [EW-1:0] pool_val;
  logic [EW-1:0] pool_ra_q;
  logic [LW-1:0] pool_lo; // lowest free count reached since reset

  assign bucket = key[64 +: BW];
  assign pop_slot = EW'(free_cnt - LW'(1));
  assign rem_head = (prev == chkv_pkg::NO_ENTRY);
  assign pool_val = pool_written ? pool_rd : pool_ra_q;

  always_comb begin
    head_we = 1'b0; head_wa = bucket; head_wd = chkv_pkg::NO_ENTRY;
    link_we = 1'b0; link_wa = EW'(cur); link_wd = chkv_pkg::NO_ENTRY;
    pool_we = 1'b0; pool_wa = EW'(free_cnt);
    if (cmd.clr_step) begin
      head_we = 1'b1; head_wa = clr_idx;
    end else if (cmd.do_add) begin
      // new entry goes in front of the current chain head
      head_we = 1'b1; head_wd = {1'b0, pool_val};
      link_we = 1'b1; link_wa = pool_val; link_wd = head_rd;
    end else if (cmd.do_rem) begin
      if (rem_head) begin
        head_we = 1'b1; head_wd = link_rd;
      end else begin
        link_we = 1'b1; link_wa = EW'(prev); link_wd = link_rd;
      end
      pool_we = (free_cnt < chkv_pkg::FULL_CNT);
    end
  end
  assign pool_ra = pop_slot;
  assign link_ra = EW'(cur);

  chkv_ram #(.WIDTH(LW), .DEPTH(chkv_pkg::BUCKETS)) u_heads (
    .clk, .we(head_we), .waddr(head_wa), .wdata(head_wd),
    .raddr(bucket), .rdata(head_rd));
  chkv_ram #(.WIDTH(LW), .DEPTH(chkv_pkg::ENTRIES)) u_links (
    .clk, .we(link_we), .waddr(link_wa), .wdata(link_wd),
    .raddr(link_ra), .rdata(link_rd));
  chkv_ram #(.WIDTH(256), .DEPTH(chkv_pkg::ENTRIES)) u_keys (
    .clk, .we(cmd.do_add), .waddr(pool_val), .wdata(key),
    .raddr(link_ra), .rdata(key_rd));
  chkv_ram #(.WIDTH(256), .DEPTH(chkv_pkg::ENTRIES)) u_vals (
    .clk, .we(cmd.do_add), .waddr(pool_val), .wdata(val),
    .raddr(link_ra), .rdata(val_rd));
  chkv_ram #(.WIDTH(EW), .DEPTH(chkv_pkg::ENTRIES)) u_pool (
    .clk, .we(pool_we), .waddr(pool_wa), .wdata(EW'(cur)),
    .raddr(pool_ra), .rdata(pool_rd));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      free_cnt <= chkv_pkg::FULL_CNT;
      pool_lo <= chkv_pkg::FULL_CNT;
    end else begin
      if (cmd.clr_step) clr_idx <= clr_idx + BW'(1);
      if (cmd.do_add) begin
        free_cnt <= free_cnt - LW'(1);
        if ({1'b0, pop_slot} < pool_lo) pool_lo <= {1'b0, pop_slot};
      end
      if (pool_we) free_cnt <= free_cnt + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    pool_ra_q <= pool_ra;
    pool_written <= ({1'b0, pool_ra} >= pool_lo);
    if (cmd.load) begin
      op <= in_op; key <= in_key; val <= in_val;
    end
    if (cmd.take_head) begin
      cur <= head_rd; prev <= chkv_pkg::NO_ENTRY; steps <= '0;
    end else if (cmd.advance) begin
      prev <= cur; cur <= link_rd; steps <= steps + LW'(1);
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
      res_val <= cmd.res_val ? val_rd : '0;
    end
  end

  assign sts.clr_last   = (clr_idx == BW'(chkv_pkg::BUCKETS - 1));
  assign sts.op         = op;
  assign sts.cur_null   = (cur == chkv_pkg::NO_ENTRY);
  assign sts.match      = (key_rd == key);
  assign sts.steps_out  = (steps >= chkv_pkg::FULL_CNT);
  assign sts.pool_empty = (free_cnt == '0);
endmodule

// ===== rtl/chkv_ctrl.sv =====
// chkv_ctrl: sequencer for clearing pass, chain walk and update
// depends on chkv_pkg
module chkv_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  chkv_pkg::chkv_sts_t sts,
  output chkv_pkg::chkv_cmd_t cmd
);
  typedef enum logic [2:0] {S_CLR, S_IDLE, S_HEAD, S_HWAIT, S_RD, S_CMP, S_POP, S_OUT}
    state_t;
  state_t state, state_next;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.load = in_fire;
        if (in_fire) state_next = S_HEAD;
      end
      S_HEAD: begin
        if (sts.op == chkv_pkg::OP_NOP) begin
          cmd.set_res = 1'b1; cmd.res_status = chkv_pkg::ST_DONE;
          state_next = S_OUT;
        end else state_next = S_HWAIT;
      end
      S_HWAIT: begin
        cmd.take_head = 1'b1; state_next = S_RD;
      end
      S_RD: begin
        if (sts.cur_null || sts.steps_out) begin
          if (sts.op == chkv_pkg::OP_ADD) begin
            if (sts.pool_empty) begin
              cmd.set_res = 1'b1; cmd.res_status = chkv_pkg::ST_FULL;
              state_next = S_OUT;
            end else state_next = S_POP;
          end else begin
            cmd.set_res = 1'b1; cmd.res_status = chkv_pkg::ST_ABSENT;
            state_next = S_OUT;
          end
        end else state_next = S_CMP;
      end
      S_CMP: begin
        if (sts.match) begin
          cmd.set_res = 1'b1;
          case (sts.op)
            chkv_pkg::OP_ADD: cmd.res_status = chkv_pkg::ST_PRESENT;
            chkv_pkg::OP_GET: begin
              cmd.res_status = chkv_pkg::ST_DONE; cmd.res_val = 1'b1;
            end
            default: begin
              cmd.res_status = chkv_pkg::ST_DONE; cmd.do_rem = 1'b1;
            end
          endcase
          state_next = S_OUT;
        end else begin
          cmd.advance = 1'b1; state_next = S_RD;
        end
      end
      S_POP: begin
        cmd.do_add = 1'b1; cmd.set_res = 1'b1; cmd.res_status = chkv_pkg::ST_DONE;
        state_next = S_OUT;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule

// ===== dv/chkv_checker.sv =====
// chkv_checker: watches the command and result streams of the hash table,
// predicts every result and compares it field by field
// depends on chkv_pkg
module chkv_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [519:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [263:0] m_tdata,
  output int           fail_count,
  output int           pending_count
);

  typedef struct packed {
    logic [1:0]   status;
    logic [255:0] value;
  } result_t;

  // shadow table: associative store keyed by the full key
  logic [255:0] stored_value [logic [255:0]];
  int           used_entries;
  result_t      expected_results [$];
  int           mismatch_count;

  assign fail_count    = mismatch_count;
  assign pending_count = expected_results.size();

  function automatic result_t table_update(input logic [519:0] cmd);
    logic [1:0]   op;
    logic [255:0] key;
    logic [255:0] val;
    result_t      r;
    op  = cmd[1:0];
    key = cmd[257:2];
    val = cmd[513:258];
    r   = '0;
    case (op)
      chkv_pkg::OP_ADD: begin
        if (stored_value.exists(key)) begin
          r.status = chkv_pkg::ST_PRESENT;
        end else if (used_entries >= int'(chkv_pkg::ENTRIES)) begin
          r.status = chkv_pkg::ST_FULL;
        end else begin
          stored_value[key] = val;
          used_entries++;
          r.status = chkv_pkg::ST_DONE;
        end
      end
      chkv_pkg::OP_GET: begin
        if (stored_value.exists(key)) begin
          r.value  = stored_value[key];
          r.status = chkv_pkg::ST_DONE;
        end else begin
          r.status = chkv_pkg::ST_ABSENT;
        end
      end
      chkv_pkg::OP_REM: begin
        if (stored_value.exists(key)) begin
          stored_value.delete(key);
          used_entries--;
          r.status = chkv_pkg::ST_DONE;
        end else begin
          r.status = chkv_pkg::ST_ABSENT;
        end
      end
      default: r.status = chkv_pkg::ST_DONE;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      stored_value.delete();
      used_entries = 0;
      mismatch_count <= 0;
      expected_results.delete();
    end else begin
      if (s_tvalid && s_tready)
        expected_results.push_back(table_update(s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("result beat with nothing expected: %h", m_tdata);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[1:0] !== want.status || m_tdata[257:2] !== want.value ||
              m_tdata[263:258] !== '0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("mismatch: status exp %0d got %0d, value exp %h got %h",
                       want.status, m_tdata[1:0], want.value, m_tdata[257:2]);
          end
        end
      end
    end
  end

endmodule

// ===== dv/testbench.sv =====
// testbench: stimulus and verdict for the chained hash key-value table
// depends on chkv_pkg, chained_hash_key_value_table, chkv_checker
module testbench;

  localparam int STALL_LIMIT = 30000;  // covers the clearing pass after reset

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [519:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [263:0] m_tdata;
  int           fail_count;
  int           pending_count;
  int           idle_cycles;
  bit           long_hold;      // receiver holds off while sender keeps offering
  bit           stall_enable;

  // keys used by the random part: few buckets, many collisions
  logic [255:0] key_pool [64];

  chained_hash_key_value_table u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  chkv_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [255:0] rand_key();
    return {rand64(), rand64(), rand64(), rand64()};
  endfunction

  // one command beat; returns at the accepting edge with tvalid still high
  task automatic send_cmd(input logic [1:0] op, input logic [255:0] key,
                          input logic [255:0] val);
    s_tdata  <= {6'd0, val, key, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic idle_gap(input int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // receiver stalls on its own pattern; a long hold-off when requested
  initial begin
    int hold;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        for (hold = 0; hold < 400; hold++) @(posedge clk);
        long_hold = 1'b0;
      end else if (stall_enable && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // watchdog: cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [255:0] k;
    logic [255:0] v;
    logic [1:0]   op;
    int           burst;
    int           n;
    rst          <= 1'b1;
    s_tvalid     <= 1'b0;
    s_tdata      <= '0;
    long_hold    = 1'b0;
    stall_enable = 1'b0;
    for (int i = 0; i < 64; i++) begin
      k = rand_key();
      k[95:64] = (i < 32) ? 32'(i % 4) : $urandom();  // shared buckets for chains
      key_pool[i] = k;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every opcode, present / absent cases, unused opcode
    send_cmd(chkv_pkg::OP_GET, '0, '0);
    send_cmd(chkv_pkg::OP_REM, '0, '0);
    send_cmd(chkv_pkg::OP_ADD, '0, '1);
    send_cmd(chkv_pkg::OP_ADD, '0, '0);   // key already present
    send_cmd(chkv_pkg::OP_GET, '0, '0);
    send_cmd(chkv_pkg::OP_ADD, '1, '0);
    send_cmd(chkv_pkg::OP_GET, '1, '1);
    send_cmd(chkv_pkg::OP_NOP, '1, '1);   // unused opcode
    k = '1; k[0] = 1'b0;                  // same bucket as all-ones, other key
    send_cmd(chkv_pkg::OP_ADD, k, {4{64'h5555_aaaa_0f0f_f0f0}});
    send_cmd(chkv_pkg::OP_GET, k, '0);
    send_cmd(chkv_pkg::OP_REM, '1, '0);   // remove chain tail
    send_cmd(chkv_pkg::OP_GET, '1, '0);
    send_cmd(chkv_pkg::OP_GET, k, '0);
    send_cmd(chkv_pkg::OP_REM, k, '0);
    send_cmd(chkv_pkg::OP_REM, '0, '0);
    send_cmd(chkv_pkg::OP_GET, '0, '0);
    drain();

    // fill the pool to the brim, then one more add for the pool-full status
    stall_enable = 1'b1;
    for (int i = 0; i < int'(chkv_pkg::ENTRIES); i++) begin
      k = '0;
      k[95:64] = 32'(i % 8);
      k[31:0]  = 32'(i);
      send_cmd(chkv_pkg::OP_ADD, k, rand_key());
      if (i == 300) long_hold = 1'b1;     // block fills up and stalls its input
      else if ($urandom_range(0, 15) == 0) idle_gap($urandom_range(1, 12));
    end
    send_cmd(chkv_pkg::OP_ADD, rand_key(), rand_key());
    send_cmd(chkv_pkg::OP_GET, k, '0);
    send_cmd(chkv_pkg::OP_REM, k, '0);
    send_cmd(chkv_pkg::OP_ADD, k, '1);    // freed entry reused
    send_cmd(chkv_pkg::OP_GET, k, '0);
    drain();                              // sender pauses until all results are in
    // free part of the table for the random traffic
    for (int i = 0; i < 48; i++) begin
      k = '0;
      k[95:64] = 32'(i % 8);
      k[31:0]  = 32'(i);
      send_cmd(chkv_pkg::OP_REM, k, '0);
    end
    drain();

    // random part: well-formed traffic on a small key set, some noise
    n = 0;
    while (n < 50) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++) begin
        op = ($urandom_range(0, 19) == 0) ? chkv_pkg::OP_NOP : 2'($urandom_range(0, 2));
        k  = ($urandom_range(0, 9) == 0) ? rand_key() : key_pool[$urandom_range(0, 63)];
        send_cmd(op, k, rand_key());
        n++;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end
    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
